// File: hw/rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_MATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic                      insert_en;
        logic                      remove_en;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } t_cmd;

endpackage

// File: hw/rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a row of slot cells and the count.
// Each command is taken in the cycle in which start is high, and busy never rises, so a
// new command may follow in every cycle. All slot cells compare against the command and
// shift by one place in that same cycle; the result strobe o_done rises in the next cycle
// with the status, the new head entry and the count. The remove search passes a found
// flag along the whole row of cells, which sets the clock period for large capacities.
module sorted_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_opcode,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_item_value,
    input  logic [spq_pkg::PRIO_W-1:0]         i_item_priority,
    output logic                               o_done,
    output logic [spq_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_head_valid,
    output logic signed [spq_pkg::VALUE_W-1:0] o_head_value,
    output logic [spq_pkg::PRIO_W-1:0]         o_head_priority,
    output logic [spq_pkg::COUNT_W-1:0]        o_entry_count
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      r_done;
    t_status                   r_status;
    t_status                   n_status;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      w_full;
    t_cmd                      w_cmd;
    logic                      w_ge    [CAPACITY];
    logic                      w_found [CAPACITY+1];
    logic signed [VALUE_W-1:0] w_value [CAPACITY];
    logic [PRIO_W-1:0]         w_prio  [CAPACITY];
    logic [CNT_W+COUNT_W-1:0]  w_count_ext;

    assign busy   = 1'b0;
    assign w_full = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_cmd.insert_en = start && (t_opcode'(i_opcode) == OP_INSERT) && !w_full;
        w_cmd.remove_en = start && (t_opcode'(i_opcode) == OP_REMOVE);
        w_cmd.value     = i_item_value;
        w_cmd.prio      = i_item_priority;
    end

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                      w_prev_ge;
        logic signed [VALUE_W-1:0] w_prev_value;
        logic [PRIO_W-1:0]         w_prev_prio;
        logic signed [VALUE_W-1:0] w_next_value;
        logic [PRIO_W-1:0]         w_next_prio;

        if (g == 0) begin : g_first
            assign w_prev_ge    = 1'b1;
            assign w_prev_value = i_item_value;
            assign w_prev_prio  = i_item_priority;
        end else begin : g_inner
            assign w_prev_ge    = w_ge[g-1];
            assign w_prev_value = w_value[g-1];
            assign w_prev_prio  = w_prio[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next_value = w_value[g];
            assign w_next_prio  = w_prio[g];
        end else begin : g_body
            assign w_next_value = w_value[g+1];
            assign w_next_prio  = w_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk           (i_clk),
            .i_cmd           (w_cmd),
            .i_held          (CNT_W'(g) < r_count),
            .i_prev_ge       (w_prev_ge),
            .i_prev_value    (w_prev_value),
            .i_prev_priority (w_prev_prio),
            .i_next_value    (w_next_value),
            .i_next_priority (w_next_prio),
            .i_found_in      (w_found[g]),
            .o_ge            (w_ge[g]),
            .o_found_out     (w_found[g+1]),
            .o_value         (w_value[g]),
            .o_priority      (w_prio[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        if (t_opcode'(i_opcode) == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_found[CAPACITY]) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                n_status = ST_NO_MATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_status <= n_status;
        end
    end

    assign w_count_ext     = {{COUNT_W{1'b0}}, r_count};
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_head_valid    = (r_count != '0);
    assign o_head_value    = o_head_valid ? w_value[0] : '0;
    assign o_head_priority = o_head_valid ? w_prio[0] : '0;
    assign o_entry_count   = w_count_ext[COUNT_W-1:0];

endmodule

// File: hw/rtl/spq_cell.sv
// One slot of the queue: holds an entry and shifts it towards either neighbour.
module spq_cell (
    input  logic                               i_clk,
    input  spq_pkg::t_cmd                      i_cmd,
    input  logic                               i_held,
    input  logic                               i_prev_ge,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_prev_value,
    input  logic [spq_pkg::PRIO_W-1:0]         i_prev_priority,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_next_value,
    input  logic [spq_pkg::PRIO_W-1:0]         i_next_priority,
    input  logic                               i_found_in,
    output logic                               o_ge,
    output logic                               o_found_out,
    output logic signed [spq_pkg::VALUE_W-1:0] o_value,
    output logic [spq_pkg::PRIO_W-1:0]         o_priority
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic [PRIO_W-1:0]         r_priority;
    logic [PRIO_W-1:0]         n_priority;

    assign o_ge        = i_held && (r_priority >= i_cmd.prio);
    assign o_found_out = i_found_in || (i_held && (r_value == i_cmd.value));
    assign o_value     = r_value;
    assign o_priority  = r_priority;

    always_comb begin
        n_value    = r_value;
        n_priority = r_priority;
        if (i_cmd.insert_en && !o_ge) begin
            if (i_prev_ge) begin
                n_value    = i_cmd.value;
                n_priority = i_cmd.prio;
            end else begin
                n_value    = i_prev_value;
                n_priority = i_prev_priority;
            end
        end else if (i_cmd.remove_en && o_found_out) begin
            n_value    = i_next_value;
            n_priority = i_next_priority;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_priority <= n_priority;
    end

endmodule

// File: dv/sorted_priority_queue_top_test.sv
// Self-checking testbench for the sorted priority queue, with directed and random command traffic.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
    import spq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        t_status                   status;
        logic                      head_valid;
        logic signed [VALUE_W-1:0] head_value;
        logic [PRIO_W-1:0]         head_priority;
        logic [COUNT_W-1:0]        entry_count;
    } t_head_report;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_opcode = 1'b0;
    logic signed [VALUE_W-1:0] i_item_value = '0;
    logic [PRIO_W-1:0]         i_item_priority = '0;
    logic                      o_done;
    logic [STATUS_W-1:0]       o_status;
    logic                      o_head_valid;
    logic signed [VALUE_W-1:0] o_head_value;
    logic [PRIO_W-1:0]         o_head_priority;
    logic [COUNT_W-1:0]        o_entry_count;

    logic signed [VALUE_W-1:0] queued_value [CAPACITY];
    logic [PRIO_W-1:0]         queued_priority [CAPACITY];
    int                        queued_count = 0;
    t_head_report              expected_reports [$];
    int                        mismatch_count = 0;
    int                        burst_left = 0;
    int                        cycle_count = 0;

    sorted_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_item_value   (i_item_value),
        .i_item_priority(i_item_priority),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_head_valid   (o_head_valid),
        .o_head_value   (o_head_value),
        .o_head_priority(o_head_priority),
        .o_entry_count  (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_head_report predict_report(t_opcode op, logic signed [VALUE_W-1:0] value,
                                                    logic [PRIO_W-1:0] prio);
        t_head_report report;
        int pos;
        report.status = ST_DONE;
        pos = 0;
        if (op == OP_INSERT) begin
            if (queued_count >= CAPACITY) begin
                report.status = ST_FULL;
            end else begin
                while (pos < queued_count && queued_priority[pos] >= prio) pos++;
                for (int k = queued_count; k > pos; k--) begin
                    queued_value[k]    = queued_value[k-1];
                    queued_priority[k] = queued_priority[k-1];
                end
                queued_value[pos]    = value;
                queued_priority[pos] = prio;
                queued_count++;
            end
        end else begin
            while (pos < queued_count && queued_value[pos] != value) pos++;
            if (pos >= queued_count) begin
                report.status = ST_NO_MATCH;
            end else begin
                for (int k = pos; k + 1 < queued_count; k++) begin
                    queued_value[k]    = queued_value[k+1];
                    queued_priority[k] = queued_priority[k+1];
                end
                queued_count--;
            end
        end
        report.head_valid    = (queued_count > 0);
        report.head_value    = (queued_count > 0) ? queued_value[0] : '0;
        report.head_priority = (queued_count > 0) ? queued_priority[0] : '0;
        report.entry_count   = COUNT_W'(queued_count);
        return report;
    endfunction

    // Predicts each accepted beat and checks each result against the oldest prediction.
    always @(posedge i_clk) begin
        t_head_report want;
        if (i_rst_n && start && !busy) begin
            expected_reports.push_back(predict_report(t_opcode'(i_opcode), i_item_value,
                                                      i_item_priority));
        end
        if (i_rst_n && o_done) begin
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("tb: unexpected result beat, status %0d count %0d",
                             o_status, o_entry_count);
            end else begin
                want = expected_reports.pop_front();
                if (o_status !== want.status || o_head_valid !== want.head_valid ||
                    o_head_value !== want.head_value ||
                    o_head_priority !== want.head_priority ||
                    o_entry_count !== want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT) begin
                        $display("tb: mismatch: expected status %0d valid %0b value %0d",
                                 want.status, want.head_valid, want.head_value);
                        $display("tb:   expected priority %0d count %0d",
                                 want.head_priority, want.entry_count);
                        $display("tb:   got status %0d valid %0b value %0d",
                                 o_status, o_head_valid, o_head_value);
                        $display("tb:   got priority %0d count %0d",
                                 o_head_priority, o_entry_count);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_command(input t_opcode op, input logic signed [VALUE_W-1:0] value,
                                input logic [PRIO_W-1:0] prio);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start           <= 1'b1;
        i_opcode        <= op;
        i_item_value    <= value;
        i_item_priority <= prio;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic test_empty_queue();
        send_command(OP_REMOVE, 32'sd5, 16'h1234);
    endtask

    task automatic test_fill_and_order();
        send_command(OP_INSERT, 32'sh7FFF_FFFF, 16'h0000);
        send_command(OP_INSERT, 32'sh8000_0000, 16'hFFFF);
        send_command(OP_INSERT, 32'sd0, 16'hFFFF);
        send_command(OP_INSERT, -32'sd1, 16'h8000);
        send_command(OP_INSERT, 32'sd7, 16'h8000);
        send_command(OP_INSERT, 32'sd7, 16'h0001);
        send_command(OP_INSERT, 32'sd7, 16'h0000);
        send_command(OP_INSERT, 32'sh5555_5555, 16'h5555);
        send_command(OP_INSERT, 32'shAAAA_AAAA, 16'hAAAA);
        for (int k = 1; k <= 7; k++)
            send_command(OP_INSERT, 32'sd100 + k, PRIO_W'(k * 16'h2100));
    endtask

    task automatic test_full_drop();
        send_command(OP_INSERT, 32'sd123, 16'hFFFF);
    endtask

    task automatic test_remove_cases();
        send_command(OP_REMOVE, 32'sd7, 16'hFFFF);
        send_command(OP_REMOVE, 32'sd999, 16'h0000);
        send_command(OP_REMOVE, 32'sh8000_0000, 16'h0000);
        send_command(OP_REMOVE, 32'sh7FFF_FFFF, 16'h0000);
        send_command(OP_REMOVE, 32'sd7, 16'h0000);
        send_command(OP_REMOVE, 32'sd7, 16'h0000);
    endtask

    task automatic test_random_traffic();
        logic signed [VALUE_W-1:0] value_pool [8];
        logic [PRIO_W-1:0]         prio_pool [4];
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        t_opcode                   op;
        int                        insert_pct;
        value_pool = '{32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd42, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sd1000};
        prio_pool  = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
        insert_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            if (op == OP_REMOVE && queued_count > 0 && $urandom_range(0, 9) < 4)
                value = queued_value[$urandom_range(0, queued_count - 1)];
            else if ($urandom_range(0, 9) < 7)
                value = value_pool[$urandom_range(0, 7)];
            else
                value = $urandom;
            if ($urandom_range(0, 9) < 4)
                prio = prio_pool[$urandom_range(0, 3)];
            else
                prio = PRIO_W'($urandom_range(0, 65535));
            send_command(op, value, prio);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_queue();
        test_fill_and_order();
        test_full_drop();
        test_remove_cases();
        test_random_traffic();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_top.sv
dv/sorted_priority_queue_top_test.sv
